### hw/rtl/sdtr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sdtr_pkg
// Shared widths, types and cathode tables for the six-digit tube roll driver.
// ----------------------------------------------------------------------------
package sdtr_pkg;

   localparam int BinWidth     = 24;
   localparam int NumDigits    = 6;
   localparam int DigitWidth   = 4;
   localparam int BcdWidth     = NumDigits * DigitWidth;
   localparam int CodeWidth    = 10;
   localparam int PatternWidth = 64;
   localparam int ValueWidth   = 20;
   localparam int CountWidth   = $clog2(BinWidth);

   typedef logic [BcdWidth-1:0]   bcd_type;
   typedef logic [DigitWidth-1:0] digit_type;

   typedef struct packed {
      logic busy;
      logic done;
   } cvt_status_type;

   // bit offset of each digit's cathode code, most significant digit first
   localparam int CodeOffset [NumDigits] = '{0, 10, 20, 32, 44, 54};

   // decimal weight of each digit, most significant digit first
   localparam logic [ValueWidth-1:0] DigitWeight [NumDigits] = '{
      20'd100000, 20'd10000, 20'd1000, 20'd100, 20'd10, 20'd1
   };

   function automatic logic [CodeWidth-1:0] cathode_code(input digit_type d);
      logic [CodeWidth-1:0] code;
      case (d)
         4'd0:    code = 10'b0000000001;
         4'd1:    code = 10'b1000000000;
         4'd2:    code = 10'b0100000000;
         4'd3:    code = 10'b0010000000;
         4'd4:    code = 10'b0001000000;
         4'd5:    code = 10'b0000100000;
         4'd6:    code = 10'b0000010000;
         4'd7:    code = 10'b0000001000;
         4'd8:    code = 10'b0000000100;
         default: code = 10'b0000000010;   // nine, and clamp anything above
      endcase
      return code;
   endfunction

   function automatic digit_type get_digit(input bcd_type bcd, input int idx);
      return bcd[BcdWidth-1-DigitWidth*idx -: DigitWidth];
   endfunction

endpackage

### hw/rtl/six_digit_tube_roll_driver.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// six_digit_tube_roll_driver
// Convert a target number to six digits and emit display frames, stepping
// each digit one count per frame when a roll is requested.
// ----------------------------------------------------------------------------
// Flow: a request is accepted only in idle, then the shift-add-3 converter
//   turns its target into decimal digits bit-serially; the control leaves
//   conversion and the frame step loads one frame per cycle into the output
//   register while the consumer does not stall, with n = 1..9 frames per
//   request; the state returns to idle as the last frame is loaded, so no
//   new request is accepted before that.
// Reset: synchronous; shown digits clear to zero and no frame is pending.
// ----------------------------------------------------------------------------
module six_digit_tube_roll_driver
   import sdtr_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   // request channel
   input  logic                    req_valid,
   output logic                    req_ready,
   input  logic [BinWidth-1:0]     req_target_value,
   input  logic                    req_roll_request,
   // frame channel
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output logic [PatternWidth-1:0] rsp_frame_pattern,
   output logic [ValueWidth-1:0]   rsp_shown_value,
   output logic                    rsp_last_frame
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_CONVERT,
      ST_FRAME
   } state_type;

   state_type               state_ff, state_in;
   logic                    roll_ff, roll_in;
   bcd_type                 shown_ff, shown_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [PatternWidth-1:0] pattern_ff, pattern_in;
   logic [ValueWidth-1:0]   value_ff, value_in;
   logic                    last_ff, last_in;

   logic                    cvt_start;
   bcd_type                 target_bcd;
   cvt_status_type          cvt_status;

   bcd_type                 step_digits;
   bcd_type                 next_digits;
   logic                    next_done;
   logic                    out_free;
   logic [PatternWidth-1:0] enc_pattern;
   logic [ValueWidth-1:0]   enc_value;

   // Start the converter on the accepting edge; it holds its result until the
   // next start, so the target digits need no copy here.
   assign cvt_start = (state_ff == ST_IDLE) && req_valid;

   sdtr_bin2bcd u_bin2bcd (
      .clock     (clock),
      .reset     (reset),
      .start     (cvt_start),
      .bin_value (req_target_value),
      .bcd_value (target_bcd),
      .status    (cvt_status)
   );

   // Advance every shown digit one count toward its target digit.
   always_comb begin
      digit_type c;
      digit_type t;
      step_digits = shown_ff;
      for (int i = 0; i < NumDigits; i++) begin
         c = get_digit(shown_ff, i);
         t = get_digit(target_bcd, i);
         if (c > t) begin
            step_digits[BcdWidth-1-DigitWidth*i -: DigitWidth] = c - 4'd1;
         end else if (c < t) begin
            step_digits[BcdWidth-1-DigitWidth*i -: DigitWidth] = c + 4'd1;
         end
      end
   end

   // Jump straight to the target without roll; otherwise finish once matched.
   assign next_digits = roll_ff ? step_digits : target_bcd;
   assign next_done   = (next_digits == target_bcd);

   sdtr_frame_enc u_frame_enc (
      .digits  (next_digits),
      .pattern (enc_pattern),
      .value   (enc_value)
   );

   // The output register takes a new frame when empty or being drained.
   assign out_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      state_in     = state_ff;
      roll_in      = roll_ff;
      shown_in     = shown_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      pattern_in   = pattern_ff;
      value_in     = value_ff;
      last_in      = last_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               roll_in  = req_roll_request;
               state_in = ST_CONVERT;
            end
         end
         ST_CONVERT: begin
            if (cvt_status.done) begin
               state_in = ST_FRAME;
            end
         end
         ST_FRAME: begin
            // hold the step until the previous frame is taken
            if (out_free) begin
               shown_in     = next_digits;
               rsp_valid_in = 1'b1;
               pattern_in   = enc_pattern;
               value_in     = enc_value;
               last_in      = next_done;
               if (next_done) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      roll_ff    <= roll_in;
      pattern_ff <= pattern_in;
      value_ff   <= value_in;
      last_ff    <= last_in;
      if (reset) begin
         state_ff     <= ST_IDLE;
         shown_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         shown_ff     <= shown_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_ready         = (state_ff == ST_IDLE);
   assign rsp_valid         = rsp_valid_ff;
   assign rsp_frame_pattern = pattern_ff;
   assign rsp_shown_value   = value_ff;
   assign rsp_last_frame    = last_ff;

endmodule

### hw/rtl/sdtr_bin2bcd.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sdtr_bin2bcd
// Iterative shift-and-add-3 converter: one binary bit per cycle, keeping only
// the six low decimal digits, which yields the value modulo one million.
// ----------------------------------------------------------------------------
module sdtr_bin2bcd
   import sdtr_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  logic [BinWidth-1:0] bin_value,
   output bcd_type             bcd_value,
   output cvt_status_type      status
);

   logic [BinWidth-1:0]   bin_ff, bin_in;
   bcd_type               bcd_ff, bcd_in;
   logic [CountWidth-1:0] count_ff, count_in;
   logic                  busy_ff, busy_in;
   logic                  done_ff, done_in;

   bcd_type               bcd_adj;

   // add three to every digit of five or more, then shift
   always_comb begin
      digit_type d;
      bcd_adj = bcd_ff;
      for (int i = 0; i < NumDigits; i++) begin
         d = bcd_ff[DigitWidth*i +: DigitWidth];
         if (d >= 4'd5) begin
            bcd_adj[DigitWidth*i +: DigitWidth] = d + 4'd3;
         end
      end
   end

   always_comb begin
      bin_in   = bin_ff;
      bcd_in   = bcd_ff;
      count_in = count_ff;
      busy_in  = busy_ff;
      done_in  = 1'b0;
      if (start) begin
         bin_in   = bin_value;
         bcd_in   = '0;
         count_in = '0;
         busy_in  = 1'b1;
      end else if (busy_ff) begin
         bcd_in   = {bcd_adj[BcdWidth-2:0], bin_ff[BinWidth-1]};
         bin_in   = {bin_ff[BinWidth-2:0], 1'b0};
         count_in = count_ff + 1'b1;
         if (count_ff == CountWidth'(BinWidth - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      bin_ff   <= bin_in;
      bcd_ff   <= bcd_in;
      count_ff <= count_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign bcd_value   = bcd_ff;
   assign status.busy = busy_ff;
   assign status.done = done_ff;

endmodule

### hw/rtl/sdtr_frame_enc.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sdtr_frame_enc
// Map six BCD digits to the packed cathode pattern and their decimal value.
// ----------------------------------------------------------------------------
module sdtr_frame_enc
   import sdtr_pkg::*;
(
   input  bcd_type                 digits,
   output logic [PatternWidth-1:0] pattern,
   output logic [ValueWidth-1:0]   value
);

   always_comb begin
      digit_type d;
      pattern = '0;
      value   = '0;
      for (int i = 0; i < NumDigits; i++) begin
         d = get_digit(digits, i);
         if (d > 4'd9) begin
            d = 4'd9;
         end
         pattern = pattern | (PatternWidth'(cathode_code(d)) << CodeOffset[i]);
         value   = value + ValueWidth'(ValueWidth'(d) * DigitWeight[i]);
      end
   end

endmodule

### sim/tube_frame_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tube_frame_checker
// Watches the request and frame channels of the six-digit tube roll driver,
// predicts every display frame from the accepted requests, and compares
// each accepted frame field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module tube_frame_checker
   import sdtr_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   input  logic                    req_ready,
   input  logic [BinWidth-1:0]     req_target_value,
   input  logic                    req_roll_request,
   input  logic                    rsp_valid,
   input  logic                    rsp_ready,
   input  logic [PatternWidth-1:0] rsp_frame_pattern,
   input  logic [ValueWidth-1:0]   rsp_shown_value,
   input  logic                    rsp_last_frame,
   output int                      mismatch_count,
   output int                      frames_pending,
   output int                      frames_checked
);

   localparam int MaxFrames = 9;

   typedef struct packed {
      logic [PatternWidth-1:0] pattern;
      logic [ValueWidth-1:0]   value;
      logic                    last;
   } frame_type;

   frame_type expected_frames [$];
   bcd_type   shown_bcd;

   // cathode code: zero drives bit 0, digit d drives bit 10 - d
   function automatic frame_type build_frame(input bcd_type digits, input logic last);
      frame_type            f;
      digit_type            d;
      logic [CodeWidth-1:0] code;
      f.pattern = '0;
      f.value   = '0;
      f.last    = last;
      for (int i = 0; i < NumDigits; i++) begin
         d = digits[BcdWidth-1-DigitWidth*i -: DigitWidth];
         code = '0;
         code[(d == 0) ? 0 : CodeWidth - d] = 1'b1;
         f.pattern[CodeOffset[i] +: CodeWidth] = code;
         f.value = f.value * 10 + d;
      end
      return f;
   endfunction

   task automatic predict_frames(input logic [BinWidth-1:0] value, input logic roll);
      logic [31:0] reduced;
      bcd_type     target_bcd;
      digit_type   cur;
      digit_type   tgt;
      logic        settled;
      int          n;
      reduced = value % 32'd1000000;
      for (int i = NumDigits - 1; i >= 0; i--) begin
         target_bcd[DigitWidth*(NumDigits-1-i) +: DigitWidth] = reduced % 10;
         reduced = reduced / 10;
      end
      if (!roll) begin
         shown_bcd = target_bcd;
         expected_frames.push_back(build_frame(shown_bcd, 1'b1));
      end else begin
         n = 0;
         settled = 1'b0;
         while (!settled) begin
            settled = 1'b1;
            for (int i = 0; i < NumDigits; i++) begin
               cur = shown_bcd[DigitWidth*i +: DigitWidth];
               tgt = target_bcd[DigitWidth*i +: DigitWidth];
               if (cur > tgt)
                  cur = cur - 1;
               else if (cur < tgt)
                  cur = cur + 1;
               shown_bcd[DigitWidth*i +: DigitWidth] = cur;
               if (cur != tgt)
                  settled = 1'b0;
            end
            n++;
            if (n >= MaxFrames)
               settled = 1'b1;
            expected_frames.push_back(build_frame(shown_bcd, settled));
         end
      end
   endtask

   always @(posedge clock) begin
      frame_type want;
      if (reset) begin
         shown_bcd = '0;
         expected_frames.delete();
         mismatch_count = 0;
         frames_checked = 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            frames_checked++;
            if (expected_frames.size() == 0) begin
               $error("frame with no request pending: pattern %h value %0d",
                      rsp_frame_pattern, rsp_shown_value);
               mismatch_count++;
            end else begin
               want = expected_frames.pop_front();
               if (rsp_frame_pattern !== want.pattern) begin
                  $error("frame_pattern: expected %h, got %h",
                         want.pattern, rsp_frame_pattern);
                  mismatch_count++;
               end
               if (rsp_shown_value !== want.value) begin
                  $error("shown_value: expected %0d, got %0d", want.value, rsp_shown_value);
                  mismatch_count++;
               end
               if (rsp_last_frame !== want.last) begin
                  $error("last_frame: expected %0d, got %0d", want.last, rsp_last_frame);
                  mismatch_count++;
               end
            end
         end
         if (req_valid && req_ready)
            predict_frames(req_target_value, req_roll_request);
      end
      frames_pending = expected_frames.size();
   end

endmodule

### sim/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives display requests into the six-digit tube roll driver: a directed
// set of corner values, then bursts of random targets, jump and roll mixed,
// under random sender gaps and receiver stalls. The frame checker predicts
// and compares; this module makes stimulus and gives the verdict.
// ----------------------------------------------------------------------------
module testbench;
   import sdtr_pkg::*;

   localparam int RandomItems = 255;
   localparam int IdleLimit   = 3000;   // cycles with no handshake at all
   localparam int DrainCycles = 40;     // settling time after the last predicted frame

   logic                    clock;
   logic                    reset;
   logic                    req_valid;
   logic                    req_ready;
   logic [BinWidth-1:0]     req_target_value;
   logic                    req_roll_request;
   logic                    rsp_valid;
   logic                    rsp_ready;
   logic [PatternWidth-1:0] rsp_frame_pattern;
   logic [ValueWidth-1:0]   rsp_shown_value;
   logic                    rsp_last_frame;

   int mismatch_count;
   int frames_pending;
   int frames_checked;
   int requests_sent;
   int rolls_sent;
   int idle_cycles;
   int stall_cycle;

   logic [BinWidth-1:0] last_target;

   six_digit_tube_roll_driver dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_target_value  (req_target_value),
      .req_roll_request  (req_roll_request),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_frame_pattern (rsp_frame_pattern),
      .rsp_shown_value   (rsp_shown_value),
      .rsp_last_frame    (rsp_last_frame)
   );

   tube_frame_checker checker_inst (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_target_value  (req_target_value),
      .req_roll_request  (req_roll_request),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_frame_pattern (rsp_frame_pattern),
      .rsp_shown_value   (rsp_shown_value),
      .rsp_last_frame    (rsp_last_frame),
      .mismatch_count    (mismatch_count),
      .frames_pending    (frames_pending),
      .frames_checked    (frames_checked)
   );

   initial clock = 1'b0;
   always #5 clock = ~clock;

   // Receiver: cycle through three stall styles in turn - always
   // ready, coin-flip ready, and a fixed stall of five out of every eight.
   always @(negedge clock) begin
      int style;
      style = (stall_cycle / 97) % 3;
      stall_cycle <= stall_cycle + 1;
      case (style)
         0: begin
            rsp_ready <= 1'b1;
         end
         1: begin
            rsp_ready <= $urandom_range(0, 1);
         end
         default: begin
            rsp_ready <= (stall_cycle % 8) < 3;
         end
      endcase
   end

   // Watchdog: stop the run when neither channel moves for too long.
   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IdleLimit) begin
         $display("RESULT: ERROR");
         $finish;
      end
   end

   // Present one request at the falling edge and hold it until accepted.
   // Valid is left high; the caller drops it only when a gap follows.
   task automatic send_request(input logic [BinWidth-1:0] value, input logic roll);
      req_valid        <= 1'b1;
      req_target_value <= value;
      req_roll_request <= roll;
      do
         @(posedge clock);
      while (!req_ready);
      @(negedge clock);
      requests_sent++;
      if (roll)
         rolls_sent++;
      last_target = value;
   endtask

   task automatic idle_sender(input int cycles);
      req_valid <= 1'b0;
      repeat (cycles) @(negedge clock);
   endtask

   initial begin
      int                  burst;
      int                  pick;
      int                  sent;
      logic [BinWidth-1:0] value;
      logic                roll;

      reset            = 1'b1;
      req_valid        = 1'b0;
      req_target_value = '0;
      req_roll_request = 1'b0;
      rsp_ready        = 1'b0;
      stall_cycle      = 0;
      idle_cycles      = 0;
      requests_sent    = 0;
      rolls_sent       = 0;
      last_target      = '0;

      // hold reset, then release on a falling edge
      repeat (4) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed part: jump and roll onto the value already shown, full
      // nine-frame rolls up and down, targets at and above one million,
      // the 24-bit maximum, mixed-direction rolls and every digit value.
      send_request(24'd0, 1'b0);
      send_request(24'd0, 1'b1);
      send_request(24'd999999, 1'b1);
      send_request(24'd0, 1'b1);
      send_request(24'd16777215, 1'b0);
      send_request(24'd1000000, 1'b0);
      send_request(24'd999999, 1'b0);
      send_request(24'd1999999, 1'b1);
      send_request(24'd16777215, 1'b1);
      send_request(24'd123456, 1'b0);
      send_request(24'd654321, 1'b1);
      send_request(24'd654321, 1'b1);
      send_request(24'd12345, 1'b1);
      send_request(24'd678901, 1'b1);
      send_request(24'd16000005, 1'b1);
      send_request(24'd543210, 1'b0);
      send_request(24'd987654, 1'b1);
      send_request(24'd1123456, 1'b1);
      send_request(24'hAAAAAA, 1'b0);
      send_request(24'h555555, 1'b1);
      idle_sender(10);

      // Random part: bursts of requests, mostly in range, some over the
      // modulus, some repeating or nudging the last target so short rolls
      // and already-shown rolls come up often.
      sent = 0;
      while (sent < RandomItems) begin
         burst = $urandom_range(1, 8);
         repeat (burst) begin
            pick = $urandom_range(0, 9);
            if (pick < 3)
               value = $urandom_range(0, 24'hFFFFFF);
            else if (pick < 7)
               value = $urandom_range(0, 999999);
            else if (pick == 7)
               value = last_target;
            else
               value = (last_target % 1000000) + $urandom_range(0, 111);
            roll = ($urandom_range(0, 9) < 6);
            send_request(value, roll);
            sent++;
         end
         // some bursts run straight into the next one
         if ($urandom_range(0, 3) != 0)
            idle_sender($urandom_range(1, 40));
      end
      req_valid <= 1'b0;

      // drain: wait for every predicted frame, then a little beyond latency
      while (frames_pending != 0)
         @(negedge clock);
      repeat (DrainCycles) @(negedge clock);

      $display("Sent %0d requests (%0d with roll), checked %0d frames, %0d mismatches.",
               requests_sent, rolls_sent, frames_checked, mismatch_count);
      if (mismatch_count == 0 && frames_pending == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

endmodule
